// ===== src/imm_pkg.sv =====
package imm_pkg;

	localparam int unsigned DIM_DEFAULT = 16;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned RC_W        = 4;
	localparam int unsigned DATA_W      = 16;
	localparam int unsigned PROD_W      = 2 * DATA_W;
	localparam int unsigned ACC_W       = 38;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

// ===== src/integer_matrix_multiply.sv =====
// Signed DIM x DIM integer matrix multiplier built around one 16x16 multiply-accumulate
// unit. A load item (command LOAD_A / LOAD_B) writes one element;
// loads outside the matrix and the unused command are dropped. A compute item for row r
// returns the DIM elements of row r of A*B in column order, last set on the final one.
// Each column streams DIM element pairs through the single read port of each matrix
// memory and the one multiplier, then drains a three-deep read/multiply/accumulate
// pipeline, so a compute item occupies the block for all DIM columns, and a stalled
// output holds it further. in_ready is low until the last column's result has been
// registered for output. The 38-bit result is exact for DIM up to 127.
module integer_matrix_multiply #(
	parameter int unsigned DIM = imm_pkg::DIM_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [imm_pkg::CMD_W-1:0]          command,
	input  logic [imm_pkg::RC_W-1:0]           row_index,
	input  logic [imm_pkg::RC_W-1:0]           col_index,
	input  logic signed [imm_pkg::DATA_W-1:0]  element_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [imm_pkg::ACC_W-1:0]   product_value,
	output logic [imm_pkg::RC_W-1:0]           out_column,
	output logic                               last
);
	import imm_pkg::*;

	localparam int unsigned IDX_W  = $clog2(DIM);
	localparam int unsigned ADDR_W = $clog2(DIM * DIM);
	localparam int unsigned DEPTH  = DIM * DIM;

	state_t state_q, state_d;

	logic [IDX_W-1:0]  k_q, c_q, row_q;
	logic              accept, row_ok, col_ok, issue, k_last, c_last;
	logic              pipe_empty, out_free, col_done, start;
	logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

	logic signed [DATA_W-1:0] mem_a [DEPTH];
	logic signed [DATA_W-1:0] mem_b [DEPTH];

	logic                     v_s1, v_s2, first_s1, first_s2;
	logic signed [DATA_W-1:0] a_rd_s1, b_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     out_valid_q, last_q;
	logic signed [ACC_W-1:0]  product_value_q;
	logic [RC_W-1:0]          out_column_q;

	assign accept     = in_valid && in_ready;
	assign row_ok     = 32'(row_index) < DIM;
	assign col_ok     = 32'(col_index) < DIM;
	assign issue      = (state_q == ST_RUN);
	assign k_last     = (k_q == IDX_W'(DIM - 1));
	assign c_last     = (c_q == IDX_W'(DIM - 1));
	assign pipe_empty = !v_s1 && !v_s2;
	assign out_free   = !out_valid_q || out_ready;
	assign col_done   = (state_q == ST_DRAIN) && pipe_empty && out_free;
	assign start      = accept && (command == CMD_COMPUTE) && row_ok;

	assign wr_addr = ADDR_W'(32'(row_index) * DIM + 32'(col_index));
	assign a_addr  = ADDR_W'(32'(row_q) * DIM + 32'(k_q));
	assign b_addr  = ADDR_W'(32'(k_q) * DIM + 32'(c_q));

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (col_done) begin
					state_d = c_last ? ST_IDLE : ST_RUN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			c_q         <= '0;
			row_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (start) begin
				row_q <= IDX_W'(row_index);
				k_q   <= '0;
				c_q   <= '0;
			end else if (issue) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end else if (col_done && !c_last) begin
				c_q <= c_q + 1'b1;
			end
			if (col_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LOAD_A) && row_ok && col_ok) begin
			mem_a[wr_addr] <= element_value;
		end
		if (issue) begin
			a_rd_s1 <= mem_a[a_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LOAD_B) && row_ok && col_ok) begin
			mem_b[wr_addr] <= element_value;
		end
		if (issue) begin
			b_rd_s1 <= mem_b[b_addr];
		end
	end

	// multiply-accumulate datapath
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		prod_s2  <= a_rd_s1 * b_rd_s1;
		first_s2 <= first_s1;
		if (v_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (col_done) begin
			product_value_q <= acc_q;
			out_column_q    <= RC_W'(c_q);
			last_q          <= c_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = product_value_q;
	assign out_column    = out_column_q;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> !in_ready)
		else $error("input taken while products in flight");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (out_column == RC_W'(DIM - 1)))
		else $error("last flag on wrong column");

	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && !pipe_empty) |=> (state_q == ST_DRAIN))
		else $error("column closed before accumulation finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !col_done)
		else $error("pending result overwritten");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam int unsigned DIM          = DIM_DEFAULT;
	localparam int          CLK_PERIOD   = 10;
	localparam int          RANDOM_ITEMS = 70;
	localparam int          HOLD_CYCLES  = 1000;
	localparam int          DRAIN_CYCLES = 400;
	localparam int          MAX_REPORTS  = 10;

	localparam logic [CMD_W-1:0]         CMD_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] ELEM_MIN   = 16'sh8000;
	localparam logic signed [DATA_W-1:0] ELEM_MAX   = 16'sh7fff;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic [RC_W-1:0]         column;
		logic                    is_last;
	} prod_elem_t;

	// Mirrors the two operand matrices and queues the product rows still owed.
	class row_product_tracker;
		logic signed [DATA_W-1:0] mat_a [DIM][DIM];
		logic signed [DATA_W-1:0] mat_b [DIM][DIM];
		prod_elem_t               owed_q[$];
		int                       failures;

		function new();
			failures = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void note_item(logic [CMD_W-1:0] cmd, logic [RC_W-1:0] r,
				logic [RC_W-1:0] k, logic signed [DATA_W-1:0] v);
			longint     acc;
			prod_elem_t e;
			if (cmd == CMD_LOAD_A) begin
				mat_a[r][k] = v;
			end else if (cmd == CMD_LOAD_B) begin
				mat_b[r][k] = v;
			end else if (cmd == CMD_COMPUTE) begin
				for (int c = 0; c < DIM; c++) begin
					acc = 0;
					for (int j = 0; j < DIM; j++)
						acc += longint'(mat_a[r][j]) * longint'(mat_b[j][c]);
					e.value   = acc[ACC_W-1:0];
					e.column  = c[RC_W-1:0];
					e.is_last = (c == DIM - 1);
					owed_q.push_back(e);
				end
			end
		endfunction

		function void check_item(logic signed [ACC_W-1:0] value, logic [RC_W-1:0] column,
				logic is_last);
			prod_elem_t e;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected product item: value %0d col %0d last %0b",
						value, column, is_last);
				return;
			end
			e = owed_q.pop_front();
			if (e.value !== value || e.column !== column || e.is_last !== is_last) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("mismatch: expected value %0d col %0d last %0b, got value %0d col %0d last %0b",
						e.value, e.column, e.is_last, value, column, is_last);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [CMD_W-1:0]            command;
	logic [RC_W-1:0]             row_index;
	logic [RC_W-1:0]             col_index;
	logic signed [DATA_W-1:0]    element_value;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [ACC_W-1:0]     product_value;
	logic [RC_W-1:0]             out_column;
	logic                        last;

	row_product_tracker sb = new();

	logic [DIM-1:0] a_written [DIM] = '{default: '0};
	logic           hold_req = 1'b0;
	int             burst_left = 0;

	integer_matrix_multiply dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.row_index(row_index),
		.col_index(col_index),
		.element_value(element_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.product_value(product_value),
		.out_column(out_column),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [DATA_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return '0;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_item(logic [CMD_W-1:0] c, logic [RC_W-1:0] r, logic [RC_W-1:0] k,
			logic [DATA_W-1:0] v);
		@(negedge clk);
		in_valid      = 1'b1;
		command       = c;
		row_index     = r;
		col_index     = k;
		element_value = v;
		do @(posedge clk); while (!in_ready);
		sb.note_item(c, r, k, v);
		if (c == CMD_LOAD_A)
			a_written[r][k] = 1'b1;
	endtask

	// Sender runs in bursts; a zero gap keeps valid high into the next item.
	task automatic offer(logic [CMD_W-1:0] c, logic [RC_W-1:0] r, logic [RC_W-1:0] k,
			logic [DATA_W-1:0] v);
		int gap;
		send_item(c, r, k, v);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_item(product_value, out_column, last);
	end

	initial begin : receiver
		int seg_left;
		int stall_pct;
		int held;
		out_ready = 1'b0;
		seg_left  = 0;
		stall_pct = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_req = 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 64);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				seg_left--;
				out_ready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin : stimulus
		int sent;
		int pick;
		int r;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		command       = CMD_LOAD_A;
		row_index     = '0;
		col_index     = '0;
		element_value = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// preload all of B and rows 0 and 15 of A; extreme columns give the
		// largest positive and negative dot products
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++)
				offer(CMD_LOAD_B, RC_W'(i), RC_W'(j), (j == 0) ? ELEM_MIN :
					(j == DIM - 1) ? ELEM_MAX : rand_elem());
		for (int j = 0; j < DIM; j++) begin
			offer(CMD_LOAD_A, 0, RC_W'(j), ELEM_MIN);
			offer(CMD_LOAD_A, RC_W'(DIM - 1), RC_W'(j), ELEM_MAX);
		end

		// directed
		offer(CMD_UNUSED, 4'hf, 4'hf, ELEM_MIN);
		offer(CMD_UNUSED, 4'h0, 4'h0, '0);
		offer(CMD_COMPUTE, 0, 4'hf, ELEM_MAX);
		offer(CMD_COMPUTE, RC_W'(DIM - 1), 4'h0, 16'hffff);
		offer(CMD_LOAD_A, 0, 0, ELEM_MAX);
		offer(CMD_LOAD_B, 0, 0, ELEM_MAX);
		offer(CMD_UNUSED, 4'h5, 4'ha, 16'h5a5a);
		offer(CMD_LOAD_A, RC_W'(DIM - 1), RC_W'(DIM - 1), ELEM_MIN);
		offer(CMD_LOAD_B, RC_W'(DIM - 1), RC_W'(DIM - 1), '0);
		offer(CMD_COMPUTE, 0, 4'h0, '0);
		offer(CMD_COMPUTE, RC_W'(DIM - 1), 4'ha, 16'ha5a5);
		offer(CMD_LOAD_A, 0, 5, '0);
		offer(CMD_LOAD_A, 0, 5, 16'h0001);
		offer(CMD_LOAD_B, 5, 9, 16'hffff);
		offer(CMD_COMPUTE, 0, 4'h9, 16'h1234);

		// let everything drain before the random part
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);

		// long output hold-off while items keep coming
		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				r = $urandom_range(0, DIM - 1);
				for (int j = 0; j < DIM; j++)
					offer(CMD_LOAD_A, RC_W'(r), RC_W'(j), rand_elem());
				offer(CMD_COMPUTE, RC_W'(r), RC_W'($urandom), DATA_W'($urandom));
				sent += DIM + 1;
			end else if (pick < 45) begin
				offer(($urandom_range(0, 1) == 0) ? CMD_LOAD_A : CMD_LOAD_B,
					RC_W'($urandom), RC_W'($urandom), rand_elem());
				sent++;
			end else if (pick < 50) begin
				offer(CMD_UNUSED, RC_W'($urandom), RC_W'($urandom), DATA_W'($urandom));
				sent++;
			end else begin
				// only rows of A that are fully written may be computed
				r = $urandom_range(0, DIM - 1);
				while (!(&a_written[r]))
					r = (r + 1) % DIM;
				offer(CMD_COMPUTE, RC_W'(r), RC_W'($urandom), DATA_W'($urandom));
				sent++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
